>>> design/adaptive_thermal_window_tracker_macros.svh
// Assertion macros shared by the thermal window tracker RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ADAPTIVE_THERMAL_WINDOW_TRACKER_MACROS_SVH
`define ADAPTIVE_THERMAL_WINDOW_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATWT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/atwt_pkg.sv
`timescale 1ns / 1ps

package atwt_pkg;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;
  localparam int AmountW  = 7;
  localparam int EdgeW    = 8;
  localparam int IrqW     = 16;

  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_EXPAND = 2'd1;
  localparam logic [1:0] REG_NARROW = 2'd2;

  localparam logic [AmountW-1:0] STEP_RESET   = 7'd2;
  localparam logic [AmountW-1:0] EXPAND_RESET = 7'd1;
  localparam logic [AmountW-1:0] NARROW_RESET = 7'd2;

  localparam logic [EdgeW-1:0] EDGE_LIMIT = 8'd127;
  localparam logic [EdgeW-1:0] RESET_LOW  = 8'd5;
  localparam logic [EdgeW-1:0] RESET_HIGH = 8'd120;
  localparam logic [IrqW-1:0]  IRQ_MAX    = 16'hFFFF;

  localparam logic FUNC_IRQ  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [AmountW-1:0] step;
    logic [AmountW-1:0] expand;
    logic [AmountW-1:0] narrow;
  } cfg_t;

  typedef struct packed {
    logic [EdgeW-1:0] low;
    logic [EdgeW-1:0] high;
    logic             grew;
    logic [IrqW-1:0]  irq;
  } win_t;

endpackage

>>> design/atwt_cfg_regs.sv
`timescale 1ns / 1ps

module atwt_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [atwt_pkg::CfgAddrW-1:0]     paddr,
  input  logic [atwt_pkg::CfgDataW-1:0]     pwdata,
  output logic [atwt_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready,
  output atwt_pkg::cfg_t                    cfg
);

  logic                 wr_en;
  logic [1:0]           reg_idx;
  atwt_pkg::cfg_t       cfg_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.step   <= atwt_pkg::STEP_RESET;
      cfg_q.expand <= atwt_pkg::EXPAND_RESET;
      cfg_q.narrow <= atwt_pkg::NARROW_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        atwt_pkg::REG_STEP:   cfg_q.step   <= pwdata[atwt_pkg::AmountW-1:0];
        atwt_pkg::REG_EXPAND: cfg_q.expand <= pwdata[atwt_pkg::AmountW-1:0];
        atwt_pkg::REG_NARROW: cfg_q.narrow <= pwdata[atwt_pkg::AmountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      atwt_pkg::REG_STEP:   prdata[atwt_pkg::AmountW-1:0] = cfg_q.step;
      atwt_pkg::REG_EXPAND: prdata[atwt_pkg::AmountW-1:0] = cfg_q.expand;
      atwt_pkg::REG_NARROW: prdata[atwt_pkg::AmountW-1:0] = cfg_q.narrow;
      default:              prdata = '0;
    endcase
  end

endmodule

>>> design/atwt_window_calc.sv
`timescale 1ns / 1ps

module atwt_window_calc (
  input  atwt_pkg::cfg_t  cfg,
  input  atwt_pkg::win_t  cur,
  input  logic            func,
  input  logic            below_low,
  input  logic            above_high,
  output atwt_pkg::win_t  nxt
);

  logic [7:0] step8;
  logic [7:0] delta;
  logic [7:0] low_a;
  logic [7:0] high_a;
  logic [8:0] high_sum;
  logic [7:0] low_b;
  logic [7:0] high_b;
  logic [9:0] size;
  logic [9:0] diff;
  logic [9:0] shrink;
  logic [7:0] q;
  logic       can_shrink;

  always_comb begin
    step8 = {1'b0, cfg.step};
    delta = step8 - {1'b0, cfg.expand};

    // Low crossing first, then the high crossing sees the moved window.
    low_a  = cur.low;
    high_a = cur.high;
    if (below_low && (cur.low >= step8)) begin
      low_a  = cur.low - step8;
      high_a = cur.high - delta;
    end
    high_sum = {1'b0, high_a} + {1'b0, step8};
    low_b  = low_a;
    high_b = high_a;
    if (above_high && (high_sum <= {1'b0, atwt_pkg::EDGE_LIMIT})) begin
      low_b  = low_a + delta;
      high_b = high_sum[7:0];
    end

    // Periodic shrink: the step is a quarter of the excess width, rounded.
    size       = {2'b00, cur.high} - {2'b00, cur.low};
    can_shrink = ($signed(size) > $signed({3'b000, cfg.narrow})) && !cur.grew;
    diff       = size - {3'b000, cfg.narrow};
    shrink     = diff + 10'd2;
    q          = shrink[9:2];

    nxt = cur;
    if (func == atwt_pkg::FUNC_TICK) begin
      if (can_shrink) begin
        if (q != 8'd0) begin
          nxt.low  = cur.low + q;
          nxt.high = cur.high - q;
        end else begin
          nxt.low = cur.low + 8'd1;
        end
      end
      nxt.grew = 1'b0;
    end else begin
      if (cur.irq != atwt_pkg::IRQ_MAX) begin
        nxt.irq = cur.irq + 16'd1;
      end
      nxt.low  = low_b;
      nxt.high = high_b;
      nxt.grew = cur.grew || below_low || above_high;
    end
  end

endmodule

>>> design/adaptive_thermal_window_tracker.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: func; tdata: below_low, above_high, zero fill to 8 bits
// m_axis    out  tdata: edge_low, edge_high, temp_estimate, irq_total (40 bits)
// APB       in   step_amount at 0x0, expand_amount at 0x4, narrowest_window at 0x8
//
// One item per cycle is accepted while the output does not stall; each item passes
// the input register, the combinational window update and the result register.
// rst is synchronous and restores the window to 5..120 with a zero interrupt count.
// A stalled output holds the input register, and s_axis_tready drops once both are full.

`include "adaptive_thermal_window_tracker_macros.svh"

module adaptive_thermal_window_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // below_low, above_high, zero fill
  input  logic                           s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // edge_low, edge_high,
                                                        // temp_estimate, irq_total
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [atwt_pkg::CfgAddrW-1:0]  paddr,
  input  logic [atwt_pkg::CfgDataW-1:0]  pwdata,
  output logic [atwt_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  atwt_pkg::cfg_t cfg;
  atwt_pkg::win_t win;
  atwt_pkg::win_t win_next;

  logic       in_valid;
  logic       in_func;
  logic       in_lo;
  logic       in_hi;
  logic       load_out;
  logic       out_valid;
  logic [7:0] edge_low;
  logic [7:0] edge_high;
  logic [7:0] temp_estimate;
  logic [15:0] irq_total;
  logic [8:0] mid_sum;

  atwt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  atwt_window_calc u_calc (
    .cfg        (cfg),
    .cur        (win),
    .func       (in_func),
    .below_low  (in_lo),
    .above_high (in_hi),
    .nxt        (win_next)
  );

  assign load_out      = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || load_out;
  assign mid_sum       = {1'b0, win_next.low} + {1'b0, win_next.high};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= s_axis_tuser;
      in_lo   <= s_axis_tdata[0];
      in_hi   <= s_axis_tdata[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win.low  <= atwt_pkg::RESET_LOW;
      win.high <= atwt_pkg::RESET_HIGH;
      win.grew <= 1'b0;
      win.irq  <= '0;
    end else if (load_out) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      edge_low      <= win_next.low;
      edge_high     <= win_next.high;
      temp_estimate <= mid_sum[8:1];
      irq_total     <= win_next.irq;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {irq_total, temp_estimate, edge_high, edge_low};

  `ATWT_ASSERT_NEXT(a_hold_item, in_valid && !load_out, in_valid, "held item was dropped")
  `ATWT_ASSERT_NEXT(a_state_idle, !load_out, $stable(win), "window changed with no item")
  `ATWT_ASSERT_NEXT(a_tick_clears, load_out && (in_func == atwt_pkg::FUNC_TICK), !win.grew,
                    "tick left grown mark set")
  `ATWT_ASSERT_NEXT(a_irq_count,
                    load_out && (in_func == atwt_pkg::FUNC_IRQ)
                      && (win.irq != atwt_pkg::IRQ_MAX),
                    win.irq == $past(win.irq) + 16'd1, "interrupt count missed")

endmodule

>>> dv/tb_adaptive_thermal_window_tracker.sv
`timescale 1ns / 1ps

module tb_adaptive_thermal_window_tracker;

  localparam int QuietLimit = 4000;

  typedef struct packed {
    logic [atwt_pkg::IrqW-1:0]  irq;
    logic [atwt_pkg::EdgeW-1:0] mid;
    logic [atwt_pkg::EdgeW-1:0] high;
    logic [atwt_pkg::EdgeW-1:0] low;
  } reading_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = 8'd0;  // below_low, above_high, zero fill
  logic                          s_axis_tuser = atwt_pkg::FUNC_IRQ;  // func
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [39:0]                   m_axis_tdata;  // edge_low, edge_high, temp_estimate, irq_total
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [atwt_pkg::CfgAddrW-1:0] paddr = '0;
  logic [atwt_pkg::CfgDataW-1:0] pwdata = '0;
  logic [atwt_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  logic [atwt_pkg::AmountW-1:0] step_deg = atwt_pkg::STEP_RESET;
  logic [atwt_pkg::AmountW-1:0] expand_deg = atwt_pkg::EXPAND_RESET;
  logic [atwt_pkg::AmountW-1:0] narrow_deg = atwt_pkg::NARROW_RESET;
  logic [atwt_pkg::EdgeW-1:0]   win_lo = atwt_pkg::RESET_LOW;
  logic [atwt_pkg::EdgeW-1:0]   win_hi = atwt_pkg::RESET_HIGH;
  logic                         win_grew = 1'b0;
  logic [atwt_pkg::IrqW-1:0]    irq_seen = '0;

  reading_t expected_readings[$];
  int       errors = 0;
  int       quiet_cycles = 0;
  bit       tx_idle_on = 1'b1;
  bit       rx_idle_on = 1'b1;
  bit       rx_hold_req = 1'b0;
  int       rx_stall = 0;

  adaptive_thermal_window_tracker DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  function automatic reading_t advance_window(input logic func, input logic lo,
                                              input logic hi);
    logic [atwt_pkg::EdgeW-1:0] shift;
    int                         span;
    int                         q;
    int                         mid;
    reading_t                   r;
    if (func == atwt_pkg::FUNC_TICK) begin
      span = int'(win_hi) - int'(win_lo);
      if (span > int'(narrow_deg) && !win_grew) begin
        q = (2 + span - int'(narrow_deg)) / 4;
        if (q != 0) begin
          win_lo = win_lo + q[atwt_pkg::EdgeW-1:0];
          win_hi = win_hi - q[atwt_pkg::EdgeW-1:0];
        end else begin
          win_lo = win_lo + 8'd1;
        end
      end
      win_grew = 1'b0;
    end else begin
      if (irq_seen != atwt_pkg::IRQ_MAX) irq_seen = irq_seen + 16'd1;
      // The move of the far edge wraps when the expansion exceeds the step.
      shift = {1'b0, step_deg} - {1'b0, expand_deg};
      if (lo) begin
        if (int'(win_lo) >= int'(step_deg)) begin
          win_lo = win_lo - {1'b0, step_deg};
          win_hi = win_hi - shift;
        end
        win_grew = 1'b1;
      end
      if (hi) begin
        if (int'(win_hi) + int'(step_deg) <= int'(atwt_pkg::EDGE_LIMIT)) begin
          win_lo = win_lo + shift;
          win_hi = win_hi + {1'b0, step_deg};
        end
        win_grew = 1'b1;
      end
    end
    mid    = (int'(win_lo) + int'(win_hi)) / 2;
    r.low  = win_lo;
    r.high = win_hi;
    r.mid  = mid[atwt_pkg::EdgeW-1:0];
    r.irq  = irq_seen;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic offer_sample(input logic func, input logic lo, input logic hi);
    int gap;
    int pick;
    gap = 0;
    if (tx_idle_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) gap = $urandom_range(6, 30);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, hi, lo};
    do @(posedge clk); while (!s_axis_tready);
    expected_readings.push_back(advance_window(func, lo, hi));
  endtask

  task automatic write_knob(input logic [1:0] idx, input logic [atwt_pkg::AmountW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(atwt_pkg::CfgDataW - atwt_pkg::AmountW){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      atwt_pkg::REG_STEP:   step_deg = val;
      atwt_pkg::REG_EXPAND: expand_deg = val;
      atwt_pkg::REG_NARROW: narrow_deg = val;
      default:              ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(atwt_pkg::CfgDataW - atwt_pkg::AmountW){1'b0}}, val}) begin
      errors++;
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input int step, input int expand, input int narrow);
    write_knob(atwt_pkg::REG_STEP, step[atwt_pkg::AmountW-1:0]);
    write_knob(atwt_pkg::REG_EXPAND, expand[atwt_pkg::AmountW-1:0]);
    write_knob(atwt_pkg::REG_NARROW, narrow[atwt_pkg::AmountW-1:0]);
  endtask

  task automatic test_reset_window();
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b0, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b1, 1'b1);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b1, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b0, 1'b1);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b1, 1'b1);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b1);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b1, 1'b0);
  endtask

  task automatic test_window_guards();
    int span;
    int step;
    apply_settings(127, 0, 0);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b1, 1'b0);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b0, 1'b1);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    apply_settings(1, 0, 127);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    // A window just one degree over the minimum creeps up by its low edge.
    span = int'(win_hi) - int'(win_lo);
    apply_settings(1, 0, (span >= 1 && span <= 128) ? span - 1 : 0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    // Step the high edge exactly onto the limit, then try to pass it.
    step = int'(atwt_pkg::EDGE_LIMIT) - int'(win_hi);
    apply_settings((step >= 1 && step <= 127) ? step : 1, 0, 2);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b0, 1'b1);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b0, 1'b1);
  endtask

  task automatic test_reverse_expansion();
    apply_settings(1, 127, 0);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b1, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    apply_settings(5, 127, 3);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b1, 1'b0);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b0, 1'b1);
    offer_sample(atwt_pkg::FUNC_TICK, 1'b0, 1'b0);
    apply_settings(127, 127, 127);
    offer_sample(atwt_pkg::FUNC_IRQ, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int step;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(2, 1, 2);
        1: apply_settings(1, 0, 0);
        2: apply_settings(127, 127, 127);
        3: begin
          step = $urandom_range(1, 20);
          apply_settings(step, $urandom_range(0, step), $urandom_range(0, 40));
        end
        4: apply_settings($urandom_range(1, 127), $urandom_range(0, 127),
                          $urandom_range(0, 127));
        default: begin
          step = $urandom_range(1, 8);
          apply_settings(step, $urandom_range(0, step), $urandom_range(0, 10));
        end
      endcase
      tx_idle_on = (phase != 1);
      rx_idle_on = (phase != 1);
      repeat (230) begin
        offer_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_req = 1'b1;
    repeat (40) begin
      offer_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end
    tx_idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall = 250;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    reading_t got;
    reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: result %h with none expected", $time, m_axis_tdata);
      end else begin
        want = expected_readings.pop_front();
        compare_field("edge_low", int'(want.low), int'(got.low));
        compare_field("edge_high", int'(want.high), int'(got.high));
        compare_field("temp_estimate", int'(want.mid), int'(got.mid));
        compare_field("irq_total", int'(want.irq), int'(got.irq));
      end
    end
  end

  // Any transfer on either stream or the register port counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_adaptive_thermal_window_tracker: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_window_guards();
    test_reverse_expansion();
    test_random_traffic();
    test_output_backpressure();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("tb_adaptive_thermal_window_tracker: clean");
    end else begin
      $display("tb_adaptive_thermal_window_tracker: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/atwt_pkg.sv
design/atwt_cfg_regs.sv
design/atwt_window_calc.sv
design/adaptive_thermal_window_tracker.sv
dv/tb_adaptive_thermal_window_tracker.sv
